### rtl/pfra_pkg.sv
package pfra_pkg;

  localparam int FRAMES  = 1024;
  localparam int FRAME_W = 10;
  localparam int CNT_W   = 11;

  localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);

  // Command codes of the input item.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_EVICT = 2'd2;
  localparam logic [1:0] CMD_MARK  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_FIRST_FRAME = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // capture the input item and set up the scan
    logic a_step;    // one frame of the alloc scan
    logic e_step;    // one frame of the evict scan
    logic take_run;  // run found: record it and set up the flag writes
    logic fail;      // no run found
    logic wr_step;   // one flag write of the found run
    logic f_load;    // latch the recorded run length for free
    logic f_step;    // one frame of the free sweep
    logic clr_step;  // one entry of the clearing pass
    logic out_load;  // load the result register
  } pfra_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic       n_zero;
    logic       a_more;
    logic       a_found;
    logic       e_in;
    logic       e_found;
    logic       f_more;
    logic       wr_last;
    logic       clr_last;
    logic       out_free;
  } pfra_stat_t;

endpackage

### rtl/pfra_dp.sv
module pfra_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pfra_pkg::CNT_W-1:0] cfg_wdata,
  input  logic [1:0]                 in_cmd,
  input  logic [pfra_pkg::CNT_W-1:0] in_npages,
  input  logic [pfra_pkg::FRAME_W-1:0] in_frame,
  input  pfra_pkg::pfra_cmd_t        ctl,
  output pfra_pkg::pfra_stat_t       stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [pfra_pkg::FRAME_W-1:0] out_base_frame,
  output logic [pfra_pkg::CNT_W-1:0] out_used_frames
);
  import pfra_pkg::*;

  // Per-frame stores.
  logic             alloc_mem [0:FRAMES-1];
  logic             user_mem  [0:FRAMES-1];
  logic [CNT_W-1:0] run_mem   [0:FRAMES-1];

  logic             alloc_q, user_q;
  logic [CNT_W-1:0] run_q;

  logic [FRAME_W-1:0] first_frame_r, first_frame_nxt;
  logic [CNT_W-1:0]   frame_count_r, frame_count_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [CNT_W-1:0]   npages_r, npages_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic               wrap_r, wrap_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;
  logic [CNT_W-1:0]   pages_r, pages_nxt;
  logic [FRAME_W-1:0] last_ev_r, last_ev_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               ok_r, ok_nxt;
  logic [FRAME_W-1:0] base_r, base_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [FRAME_W-1:0] out_base_r, out_base_nxt;
  logic [CNT_W-1:0]   out_used_r, out_used_nxt;

  logic [CNT_W-1:0]   pc, last_p1, lim_wrap, cnt_p1, idx_p1, base_calc, ff_ext;
  logic               hit;

  logic               alloc_we, alloc_wd, user_we, user_wd, run_we;
  logic [FRAME_W-1:0] flag_wa, run_wa, rd_a;
  logic [CNT_W-1:0]   run_wd;

  assign pc        = (frame_count_r > FRAMES_C) ? FRAMES_C : frame_count_r;
  assign ff_ext    = {1'b0, first_frame_r};
  assign last_p1   = {1'b0, last_ev_r} + CNT_W'(1);
  assign lim_wrap  = (last_p1 > pc) ? pc : last_p1;
  assign hit       = alloc_q & user_q;
  assign cnt_p1    = cnt_r + CNT_W'(1);
  assign idx_p1    = idx_r + CNT_W'(1);
  assign base_calc = ((op_r == CMD_EVICT) ? idx_p1 : idx_r) - npages_r;

  always_comb begin
    stat.op       = op_r;
    stat.n_zero   = (npages_r == '0);
    stat.a_more   = (idx_r < pc) && (cnt_r != npages_r);
    stat.a_found  = (cnt_r == npages_r);
    stat.e_in     = (idx_r < lim_r);
    stat.e_found  = hit && (cnt_p1 == npages_r);
    stat.f_more   = (cnt_r < pages_r) && !idx_r[FRAME_W];
    stat.wr_last  = (idx_p1 == end_r);
    stat.clr_last = (idx_r == FRAMES_C - CNT_W'(1));
    stat.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    first_frame_nxt = first_frame_r;
    frame_count_nxt = frame_count_r;
    op_nxt          = op_r;
    npages_nxt      = npages_r;
    frame_nxt       = frame_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    lim_nxt         = lim_r;
    wrap_nxt        = wrap_r;
    end_nxt         = end_r;
    pages_nxt       = pages_r;
    last_ev_nxt     = last_ev_r;
    used_nxt        = used_r;
    ok_nxt          = ok_r;
    base_nxt        = base_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_ok_nxt      = out_ok_r;
    out_base_nxt    = out_base_r;
    out_used_nxt    = out_used_r;

    if (cfg_we) begin
      if (cfg_index == REG_FIRST_FRAME) begin
        first_frame_nxt = cfg_wdata[FRAME_W-1:0];
      end else begin
        frame_count_nxt = cfg_wdata;
      end
    end

    if (ctl.start) begin
      op_nxt     = in_cmd;
      npages_nxt = in_npages;
      frame_nxt  = in_frame;
      cnt_nxt    = '0;
      ok_nxt     = 1'b1;
      base_nxt   = in_frame;
      lim_nxt    = pc;
      wrap_nxt   = 1'b0;
      case (in_cmd)
        CMD_ALLOC: begin
          idx_nxt = ff_ext;
        end
        CMD_EVICT: begin
          // With the pointer on the final frame the scan restarts past
          // first_frame and makes no second pass.
          if (last_p1 == pc) begin
            idx_nxt = ff_ext + CNT_W'(1);
          end else begin
            idx_nxt  = last_p1;
            wrap_nxt = 1'b1;
          end
        end
        default: begin
          idx_nxt = {1'b0, in_frame};
        end
      endcase
    end

    if (ctl.a_step) begin
      cnt_nxt = alloc_q ? '0 : cnt_p1;
      idx_nxt = idx_p1;
    end

    if (ctl.e_step) begin
      cnt_nxt = hit ? cnt_p1 : '0;
      if (wrap_r && (idx_p1 == lim_r)) begin
        // End of the first pass: go around once, up to the old pointer.
        lim_nxt  = lim_wrap;
        idx_nxt  = ff_ext;
        cnt_nxt  = '0;
        wrap_nxt = 1'b0;
      end else begin
        idx_nxt = idx_p1;
      end
    end

    if (ctl.take_run) begin
      idx_nxt  = base_calc;
      end_nxt  = (op_r == CMD_EVICT) ? idx_p1 : idx_r;
      base_nxt = base_calc[FRAME_W-1:0];
      ok_nxt   = 1'b1;
      if (op_r == CMD_EVICT) begin
        last_ev_nxt = idx_r[FRAME_W-1:0];
      end else begin
        used_nxt = used_r + npages_r;
      end
    end

    if (ctl.fail) begin
      ok_nxt   = 1'b0;
      base_nxt = '0;
    end

    if (ctl.wr_step || ctl.clr_step) begin
      idx_nxt = idx_p1;
    end

    if (ctl.f_load) begin
      pages_nxt = run_q;
      cnt_nxt   = '0;
    end

    if (ctl.f_step) begin
      idx_nxt = idx_p1;
      cnt_nxt = cnt_p1;
      if (alloc_q) begin
        used_nxt = used_r - CNT_W'(1);
      end
    end

    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok_r;
      out_base_nxt  = base_r;
      out_used_nxt  = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frame_r <= '0;
      frame_count_r <= FRAMES_C;
      idx_r         <= '0;
      last_ev_r     <= '0;
      used_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      first_frame_r <= first_frame_nxt;
      frame_count_r <= frame_count_nxt;
      idx_r         <= idx_nxt;
      last_ev_r     <= last_ev_nxt;
      used_r        <= used_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    npages_r   <= npages_nxt;
    frame_r    <= frame_nxt;
    cnt_r      <= cnt_nxt;
    lim_r      <= lim_nxt;
    wrap_r     <= wrap_nxt;
    end_r      <= end_nxt;
    pages_r    <= pages_nxt;
    ok_r       <= ok_nxt;
    base_r     <= base_nxt;
    out_ok_r   <= out_ok_nxt;
    out_base_r <= out_base_nxt;
    out_used_r <= out_used_nxt;
  end

  // The flag stores are read at the next index, so their data always
  // belongs to the frame that idx_r points at during a scan or sweep.
  assign rd_a     = idx_nxt[FRAME_W-1:0];
  assign flag_wa  = ctl.start ? in_frame : idx_r[FRAME_W-1:0];
  assign alloc_we = ctl.clr_step || ctl.f_step || (ctl.wr_step && (op_r == CMD_ALLOC));
  assign alloc_wd = ctl.wr_step;
  assign user_we  = ctl.clr_step || ctl.f_step || ctl.wr_step ||
                    (ctl.start && (in_cmd == CMD_MARK));
  assign user_wd  = ctl.start;
  assign run_we   = ctl.clr_step || ctl.f_load || ctl.take_run;
  assign run_wa   = ctl.f_load   ? frame_r :
                    ctl.take_run ? base_calc[FRAME_W-1:0] : idx_r[FRAME_W-1:0];
  assign run_wd   = ctl.take_run ? npages_r : '0;

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      alloc_mem[flag_wa] <= alloc_wd;
    end
    alloc_q <= alloc_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (user_we) begin
      user_mem[flag_wa] <= user_wd;
    end
    user_q <= user_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_wa] <= run_wd;
    end
    run_q <= run_mem[rd_a];
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_base_frame  = out_base_r;
  assign out_used_frames = out_used_r;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FRAMES_C)
    else $error("allocated frame count exceeds the frame total");

  a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_step |-> (idx_r < end_r))
    else $error("flag write outside the found run");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.a_step || ctl.e_step) |-> (cnt_r < npages_r))
    else $error("scan run count reached the request without stopping");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over one not yet transferred");

  a_used_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!ctl.take_run && !ctl.f_step) |=> $stable(used_r))
    else $error("allocated frame count changed outside alloc or free");
`endif

endmodule

### rtl/pfra_ctrl.sv
module pfra_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfra_pkg::pfra_stat_t stat,
  output pfra_pkg::pfra_cmd_t  ctl
);
  import pfra_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_ASCAN  = 4'd3;
  localparam logic [3:0] S_ESCAN  = 4'd4;
  localparam logic [3:0] S_FREAD  = 4'd5;
  localparam logic [3:0] S_FLOOP  = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          CMD_ALLOC: begin
            if (stat.n_zero) begin
              ctl.fail  = 1'b1;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_ASCAN;
            end
          end
          CMD_EVICT: begin
            if (stat.n_zero) begin
              ctl.fail  = 1'b1;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_ESCAN;
            end
          end
          CMD_FREE: begin
            state_nxt = S_FREAD;
          end
          default: begin
            // Mark was written when the item was taken.
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_ASCAN: begin
        if (stat.a_more) begin
          ctl.a_step = 1'b1;
        end else if (stat.a_found) begin
          ctl.take_run = 1'b1;
          state_nxt    = S_WRITE;
        end else begin
          ctl.fail  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_ESCAN: begin
        if (!stat.e_in) begin
          ctl.fail  = 1'b1;
          state_nxt = S_FINISH;
        end else if (stat.e_found) begin
          ctl.take_run = 1'b1;
          state_nxt    = S_WRITE;
        end else begin
          ctl.e_step = 1'b1;
        end
      end
      S_FREAD: begin
        ctl.f_load = 1'b1;
        state_nxt  = S_FLOOP;
      end
      S_FLOOP: begin
        if (stat.f_more) begin
          ctl.f_step = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WRITE: begin
        ctl.wr_step = 1'b1;
        if (stat.wr_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/page_frame_run_allocator.sv
// Mark writes its flag when the item is taken; free sweeps the recorded run; alloc and
// evict scan frames (evict up to all present frames, across the wrap), then write the run.
// One item is in work at a time; the scan and the flag writes take one frame per cycle,
// set by the single read and write port of the per-frame flag stores.
// Reset (synchronous, rst_n low) is followed by a clearing pass over every entry of the
// per-frame stores; no input transfer is taken until it ends, config writes are.
module page_frame_run_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pfra_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_cmd,
  input  logic [pfra_pkg::CNT_W-1:0]   in_npages,
  input  logic [pfra_pkg::FRAME_W-1:0] in_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [pfra_pkg::FRAME_W-1:0] out_base_frame,
  output logic [pfra_pkg::CNT_W-1:0]   out_used_frames
);
  import pfra_pkg::*;

  pfra_cmd_t  ctl;
  pfra_stat_t stat;

  pfra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  pfra_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_npages       (in_npages),
    .in_frame        (in_frame),
    .ctl             (ctl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_base_frame  (out_base_frame),
    .out_used_frames (out_used_frames)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pfra_pkg::*;

  localparam int HOLD_LEN     = 300;
  localparam int QUIET_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 2100;

  typedef struct {
    logic [1:0]         cmd;
    logic [CNT_W-1:0]   npages;
    logic [FRAME_W-1:0] frame;
  } frame_req_t;

  typedef struct {
    logic               ok;
    logic [FRAME_W-1:0] base;
    logic [CNT_W-1:0]   used;
  } alloc_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = '0;
  logic [CNT_W-1:0]   in_npages = '0;
  logic [FRAME_W-1:0] in_frame = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [FRAME_W-1:0] out_base_frame;
  logic [CNT_W-1:0]   out_used_frames;

  // Shadow copy of the frame table and the registers.
  bit frame_alloc [FRAMES];
  bit frame_user  [FRAMES];
  int frame_run   [FRAMES];
  int evict_ptr   = 0;
  int alloc_total = 0;
  int cfg_first   = 0;
  int cfg_count   = FRAMES;

  frame_req_t   request_queue[$];
  alloc_reply_t expected_replies[$];

  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  int   hold_left      = 0;
  logic start_hold     = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;

  page_frame_run_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_npages       (in_npages),
    .in_frame        (in_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_base_frame  (out_base_frame),
    .out_used_frames (out_used_frames)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic alloc_reply_t serve_request(logic [1:0] cmd, int n, int f);
    alloc_reply_t r;
    int top, cnt, i, b, k, last, lim;
    bit wrap, hit;
    r.ok = 1'b1;
    r.base = FRAME_W'(f);
    top = (cfg_count > FRAMES) ? FRAMES : cfg_count;
    case (cmd)
      CMD_ALLOC: begin
        cnt = 0;
        i = cfg_first;
        if (n != 0) begin
          while (i < top && cnt != n) begin
            cnt = frame_alloc[i] ? 0 : cnt + 1;
            i++;
          end
        end
        if (n == 0 || cnt < n) begin
          r.ok = 1'b0;
        end else begin
          b = i - n;
          for (k = b; k < i; k++) begin
            frame_alloc[k] = 1'b1;
            frame_user[k] = 1'b0;
          end
          frame_run[b] = n;
          alloc_total += n;
          r.base = FRAME_W'(b);
        end
      end
      CMD_FREE: begin
        cnt = frame_run[f];
        frame_run[f] = 0;
        for (k = 0; k < cnt && f + k < FRAMES; k++) begin
          if (frame_alloc[f + k]) alloc_total--;
          frame_alloc[f + k] = 1'b0;
          frame_user[f + k] = 1'b0;
        end
      end
      CMD_EVICT: begin
        hit = 1'b0;
        i = 0;
        if (n != 0) begin
          last = evict_ptr;
          lim = top;
          wrap = 1'b1;
          cnt = 0;
          // With the pointer on the final frame the scan restarts above
          // first_frame and gets no second pass.
          if (evict_ptr + 1 == top) begin
            last = cfg_first;
            wrap = 1'b0;
          end
          i = last + 1;
          while (i < lim && !hit) begin
            if (frame_alloc[i] && frame_user[i]) begin
              cnt++;
              if (cnt == n) hit = 1'b1;
            end else begin
              cnt = 0;
            end
            if (!hit && wrap && i == lim - 1) begin
              lim = (last + 1 > top) ? top : last + 1;
              i = cfg_first;
              cnt = 0;
              wrap = 1'b0;
            end else begin
              i++;
            end
          end
        end
        if (!hit) begin
          r.ok = 1'b0;
        end else begin
          evict_ptr = i - 1;
          b = i - n;
          for (k = b; k < i; k++) frame_user[k] = 1'b0;
          frame_run[b] = n;
          r.base = FRAME_W'(b);
        end
      end
      CMD_MARK: begin
        frame_user[f] = 1'b1;
      end
    endcase
    if (!r.ok) r.base = '0;
    r.used = CNT_W'(alloc_total);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void push_req(logic [1:0] cmd, int n, int f);
    frame_req_t q;
    q.cmd = cmd;
    q.npages = CNT_W'(n);
    q.frame = FRAME_W'(f);
    request_queue.push_back(q);
  endfunction

  // Looks for a frame with a recorded run inside the managed window, so that
  // frees and marks land on live allocations most of the time.
  function automatic int find_run(int lo, int w);
    int s, f, k;
    if (w <= 0) return $urandom_range(FRAMES - 1);
    s = $urandom_range(w - 1);
    for (k = 0; k < w; k++) begin
      f = lo + (s + k) % w;
      if (frame_run[f] != 0) return f;
    end
    return lo + s;
  endfunction

  function automatic int pick_len(int w);
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 86) return 0;
    if (r < 93 && w > 0) return w;
    return $urandom_range(2047);
  endfunction

  task automatic queue_random(int total);
    int lo, hi, w, r, b, len, made, k;
    lo = cfg_first;
    hi = (cfg_count > FRAMES) ? FRAMES : cfg_count;
    w = hi - lo;
    made = 0;
    while (made < total) begin
      r = $urandom_range(99);
      if (r < 28) begin
        push_req(CMD_ALLOC, pick_len(w), $urandom_range(FRAMES - 1));
        made++;
      end else if (r < 52) begin
        // Mark part of a live run as user pages, then often evict it.
        b = find_run(lo, w);
        len = frame_run[b];
        if (len == 0) len = 1;
        if (len > 6) len = $urandom_range(1, 6);
        for (k = 0; k < len && b + k < FRAMES; k++) begin
          push_req(CMD_MARK, $urandom_range(2047), b + k);
          made++;
        end
        if ($urandom_range(1) == 1) begin
          push_req(CMD_EVICT, $urandom_range(1, len), $urandom_range(FRAMES - 1));
          made++;
        end
      end else if (r < 68) begin
        push_req(CMD_EVICT, pick_len(w), $urandom_range(FRAMES - 1));
        made++;
      end else if (r < 88) begin
        push_req(CMD_FREE, $urandom_range(2047),
                 ($urandom_range(9) == 0) ? $urandom_range(FRAMES - 1) : find_run(lo, w));
        made++;
      end else begin
        push_req(2'($urandom_range(3)), $urandom_range(2047), $urandom_range(FRAMES - 1));
        made++;
      end
      // Keep the backlog short so the shadow table stays close to the block.
      while (request_queue.size() > 2) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_replies.size() != 0);
  endtask

  task automatic write_register(logic idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIRST_FRAME) begin
      cfg_first = value & 'h3FF;
    end else begin
      cfg_count = value & 'h7FF;
    end
  endtask

  task automatic run_phase(int first, int count, int s_idle, int r_idle, int items, bit hold);
    write_register(REG_FIRST_FRAME, first);
    write_register(REG_FRAME_COUNT, count);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (hold) begin
      @(posedge clk);
      start_hold <= 1'b1;
      @(posedge clk);
      start_hold <= 1'b0;
    end
    queue_random(items);
    wait_idle();
  endtask

  // Sender: one transfer per handshake, the next item or a gap after it.
  always @(posedge clk) begin : drive_requests
    frame_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(serve_request(in_cmd, int'(in_npages), int'(in_frame)));
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_queue.pop_front();
          in_valid <= 1'b1;
          in_cmd <= nxt.cmd;
          in_npages <= nxt.npages;
          in_frame <= nxt.frame;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      out_ready <= 1'b0;
    end else if (start_hold) begin
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_replies
    alloc_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("result with none pending, base_frame", out_base_frame, -1);
      end else begin
        want = expected_replies.pop_front();
        if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
        if (out_base_frame !== want.base) report_mismatch("base_frame", out_base_frame, want.base);
        if (out_used_frames !== want.used) begin
          report_mismatch("used_frames", out_used_frames, want.used);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("page_frame_run_allocator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 55;
    // Hand-picked sequence on the reset settings: zero-length requests, a run
    // split by the wrap point, an evict that wraps, the pointer left on the
    // final frame, marking a free frame and whole-table alloc and free.
    push_req(CMD_ALLOC, 0, 0);
    push_req(CMD_ALLOC, 2, 0);
    push_req(CMD_MARK, 0, 0);
    push_req(CMD_MARK, 0, 1);
    push_req(CMD_EVICT, 2, 0);
    push_req(CMD_EVICT, 1, 0);
    push_req(CMD_EVICT, 1, 0);
    push_req(CMD_EVICT, 0, 1023);
    push_req(CMD_EVICT, 1, 0);
    push_req(CMD_FREE, 0, 0);
    push_req(CMD_FREE, 0, 1);
    push_req(CMD_FREE, 0, 700);
    push_req(CMD_MARK, 2047, 1023);
    push_req(CMD_ALLOC, 1024, 0);
    push_req(CMD_ALLOC, 1, 0);
    push_req(CMD_MARK, 0, 1022);
    push_req(CMD_MARK, 0, 1023);
    push_req(CMD_EVICT, 2, 0);
    push_req(CMD_MARK, 0, 1);
    push_req(CMD_MARK, 0, 2);
    push_req(CMD_EVICT, 2, 0);
    push_req(CMD_FREE, 0, 0);
    push_req(CMD_FREE, 0, 1022);
    push_req(CMD_ALLOC, 2047, 1023);
    wait_idle();

    run_phase(0, 1024, 9, 55, 100, 1'b0);
    run_phase(1000, 1024, 9, 55, 100, 1'b0);
    run_phase(900, 2047, 55, 9, 100, 1'b0);
    run_phase(3, 40, 55, 9, 100, 1'b0);
    run_phase(1023, 1024, 0, 0, 40, 1'b0);
    run_phase(600, 0, 0, 0, 20, 1'b0);
    run_phase(0, 64, 0, 0, 100, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("page_frame_run_allocator: match");
    end else begin
      $display("page_frame_run_allocator: mismatch");
    end
    $finish;
  end

endmodule

### page_frame_run_allocator.f
rtl/pfra_pkg.sv
rtl/pfra_dp.sv
rtl/pfra_ctrl.sv
rtl/page_frame_run_allocator.sv
tb/tb_top.sv
